FILE: sv/sfc_pkg.sv
// ---------------------------------------------------------------------------
// sfc_pkg: shared types, codes and opcode tables for the SPI NOR sequencer
// Action, command, phase and result-kind codes plus the header byte lookup.
// ---------------------------------------------------------------------------
package sfc_pkg;

	localparam int MAX_RES = 4;
	localparam int IDX_W   = $clog2(MAX_RES);
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_HOST  = 2'd1,
		ACT_SPI   = 2'd2
	} action_t;

	localparam logic [3:0] CMD_READ   = 4'd0;
	localparam logic [3:0] CMD_WRITE  = 4'd1;
	localparam logic [3:0] CMD_SERASE = 4'd2;
	localparam logic [3:0] CMD_CERASE = 4'd3;
	localparam logic [3:0] CMD_ID     = 4'd4;
	localparam logic [3:0] CMD_ST1    = 4'd5;
	localparam logic [3:0] CMD_ST2    = 4'd6;
	localparam logic [3:0] CMD_WRST   = 4'd7;
	localparam logic [3:0] CMD_SECWR  = 4'd8;
	localparam logic [3:0] CMD_SECRD  = 4'd9;
	localparam logic [3:0] CMD_SECER  = 4'd10;
	localparam logic [3:0] CMD_PD     = 4'd11;
	localparam logic [3:0] CMD_WAKE   = 4'd12;

	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_PP    = 8'h02;
	localparam logic [7:0] OP_SE    = 8'h20;
	localparam logic [7:0] OP_CE    = 8'hC7;
	localparam logic [7:0] OP_JEDEC = 8'h9F;
	localparam logic [7:0] OP_RDSR1 = 8'h05;
	localparam logic [7:0] OP_RDSR2 = 8'h35;
	localparam logic [7:0] OP_WRSR  = 8'h01;
	localparam logic [7:0] OP_SECWR = 8'h42;
	localparam logic [7:0] OP_SECRD = 8'h48;
	localparam logic [7:0] OP_SECER = 8'h44;
	localparam logic [7:0] OP_PD    = 8'hB9;
	localparam logic [7:0] OP_WAKE  = 8'hAB;
	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_DUMMY = 8'hFF;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_WREN      = 5'd1,
		PH_HDR       = 5'd2,
		PH_PRE_CMD   = 5'd3,
		PH_PRE_WAIT  = 5'd4,
		PH_POST_CMD  = 5'd5,
		PH_POST_WAIT = 5'd6,
		PH_DREQ      = 5'd7,
		PH_DWAIT     = 5'd8,
		PH_READ      = 5'd9
	} phase_t;

	typedef enum logic [2:0] {
		KIND_SEND    = 3'd0,
		KIND_RELEASE = 3'd1,
		KIND_READ    = 3'd2,
		KIND_REQ     = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  command;
		logic [23:0] address;
		logic [15:0] length;
		logic [7:0]  data_byte;
	} sfc_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  spi;
		logic [7:0]  host;
		logic [23:0] value;
	} sfc_res_t;

	function automatic logic [7:0] op_byte(input logic [3:0] ac);
		case (ac)
			CMD_READ:   return OP_READ;
			CMD_WRITE:  return OP_PP;
			CMD_SERASE: return OP_SE;
			CMD_CERASE: return OP_CE;
			CMD_ID:     return OP_JEDEC;
			CMD_ST1:    return OP_RDSR1;
			CMD_ST2:    return OP_RDSR2;
			CMD_WRST:   return OP_WRSR;
			CMD_SECWR:  return OP_SECWR;
			CMD_SECRD:  return OP_SECRD;
			CMD_SECER:  return OP_SECER;
			CMD_PD:     return OP_PD;
			CMD_WAKE:   return OP_WAKE;
			default:    return 8'h00;
		endcase
	endfunction

	// header length in bytes, opcode included
	function automatic logic [2:0] hdr_len(input logic [3:0] ac);
		case (ac) inside
			CMD_READ, CMD_WRITE, CMD_SERASE, CMD_SECWR, CMD_SECER: return 3'd4;
			CMD_SECRD: return 3'd5;
			default:   return 3'd1;
		endcase
	endfunction

	function automatic logic needs_wren(input logic [3:0] ac);
		case (ac) inside
			CMD_WRITE, CMD_SERASE, CMD_CERASE, CMD_WRST, CMD_SECWR, CMD_SECER: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] header_byte(input logic [2:0] i, input logic [3:0] ac,
			input logic [23:0] addr);
		case (i)
			3'd0:    return op_byte(ac);
			3'd1:    return addr[23:16];
			3'd2:    return addr[15:8];
			3'd3:    return addr[7:0];
			default: return OP_DUMMY;
		endcase
	endfunction

	function automatic sfc_res_t send_res(input logic [7:0] b);
		sfc_res_t r;
		r = '0;
		r.kind = KIND_SEND;
		r.spi = b;
		return r;
	endfunction

	function automatic sfc_res_t rel_res();
		sfc_res_t r;
		r = '0;
		r.kind = KIND_RELEASE;
		return r;
	endfunction

	function automatic sfc_res_t read_res(input logic [7:0] d);
		sfc_res_t r;
		r = '0;
		r.kind = KIND_READ;
		r.host = d;
		return r;
	endfunction

	function automatic sfc_res_t req_res();
		sfc_res_t r;
		r = '0;
		r.kind = KIND_REQ;
		return r;
	endfunction

	// done carries the id or status only for the id and status reads
	function automatic sfc_res_t done_res(input logic [3:0] ac, input logic [23:0] ida);
		sfc_res_t r;
		r = '0;
		r.kind = KIND_DONE;
		if (ac == CMD_ID || ac == CMD_ST1 || ac == CMD_ST2) begin
			r.value = ida;
		end
		return r;
	endfunction

endpackage

FILE: sv/sfc_in_if.sv
// ---------------------------------------------------------------------------
// sfc_in_if: request channel into the sequencer
// Valid/ready handshake with start, host-byte and SPI-byte payload.
// ---------------------------------------------------------------------------
interface sfc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [3:0]  command;
	logic [23:0] address;
	logic [15:0] length;
	logic [7:0]  data_byte;

	modport source (output valid, action, command, address, length, data_byte, input ready);
	modport sink (input valid, action, command, address, length, data_byte, output ready);
endinterface

FILE: sv/sfc_out_if.sv
// ---------------------------------------------------------------------------
// sfc_out_if: result channel out of the sequencer
// Valid/ready handshake carrying the results of each request in order.
// ---------------------------------------------------------------------------
interface sfc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_kind;
	logic [7:0]  spi_byte;
	logic [7:0]  host_byte;
	logic [23:0] result_value;
	logic        last;

	modport source (output valid, out_kind, spi_byte, host_byte, result_value, last,
		input ready);
	modport sink (input valid, out_kind, spi_byte, host_byte, result_value, last,
		output ready);
endinterface

FILE: sv/sfc_in_pipe.sv
// ---------------------------------------------------------------------------
// sfc_in_pipe: input register stages with page offset computation
// Three stages; the address is reduced modulo the page size by a reciprocal
// multiply in stage one and a back-multiply and subtract in stage two.
// ---------------------------------------------------------------------------
module sfc_in_pipe #(
	parameter int PAGE_BYTES = 256,
	localparam int OFF_W = $clog2(PAGE_BYTES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sfc_in_if.sink               cmd,
	input  logic                 take,
	output logic                 vld,
	output sfc_pkg::sfc_item_t   item,
	output logic [OFF_W-1:0]     off
);
	import sfc_pkg::*;

	localparam int SH    = 24 + OFF_W;
	localparam int RW    = 26;
	// ceil(2^SH / PAGE_BYTES): exact quotient for every 24-bit address
	localparam logic [63:0] RECIP_L =
		((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
	localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];
	// wide enough that the quotient field sits inside the product
	localparam int PW    = SH + 24;

	logic              v_s1, v_s2, v_s3;
	sfc_item_t         item_s1, item_s2, item_s3;
	logic [23:0]       quo_s2;
	logic [OFF_W-1:0]  off_s3;
	logic              en1, en2, en3;
	logic [PW-1:0]     prod;
	logic [23:0]       quo;
	logic [37:0]       back;
	logic [23:0]       rem_full;
	logic [23:0]       rem_fix;
	sfc_item_t         item_in;

	assign en3 = !v_s3 || take;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign cmd.ready = en1;

	assign item_in = '{action: cmd.action, command: cmd.command, address: cmd.address,
		length: cmd.length, data_byte: cmd.data_byte};

	assign prod = PW'(item_s1.address) * PW'(RECIP);
	assign quo  = prod[SH +: 24];

	assign back     = 38'(quo_s2) * 38'(PAGE_BYTES);
	assign rem_full = item_s2.address - back[23:0];
	assign rem_fix  = (rem_full >= 24'(PAGE_BYTES)) ? rem_full - 24'(PAGE_BYTES) : rem_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cmd.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1 <= item_in;
		end
		if (en2) begin
			item_s2 <= item_s1;
			quo_s2  <= quo;
		end
		if (en3) begin
			item_s3 <= item_s2;
			off_s3  <= rem_fix[OFF_W-1:0];
		end
	end

	assign vld  = v_s3;
	assign item = item_s3;
	assign off  = off_s3;

endmodule

FILE: sv/sfc_core.sv
// ---------------------------------------------------------------------------
// sfc_core: command sequencer state and one-step result generation
// Applies one request to the sequencer state and forms its results.
// ---------------------------------------------------------------------------
module sfc_core #(
	parameter int PAGE_BYTES = 256,
	localparam int OFF_W   = $clog2(PAGE_BYTES),
	localparam int CHUNK_W = $clog2(PAGE_BYTES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  sfc_pkg::sfc_item_t          item,
	input  logic [OFF_W-1:0]            item_off,
	output sfc_pkg::sfc_res_t           res [sfc_pkg::MAX_RES],
	output logic [sfc_pkg::CNT_W-1:0]   res_cnt
);
	import sfc_pkg::*;

	phase_t              phase_q;
	logic [3:0]          cmd_q;
	logic [23:0]         cur_q;
	logic [15:0]         rem_q;
	logic [CHUNK_W-1:0]  chk_q;
	logic [2:0]          hix_q;
	logic [23:0]         ida_q;
	logic [OFF_W-1:0]    off_q;

	phase_t              ph;
	logic [3:0]          ac;
	logic [23:0]         cur;
	logic [15:0]         rem;
	logic [CHUNK_W-1:0]  chk;
	logic [2:0]          hix;
	logic [23:0]         ida;
	logic [OFF_W-1:0]    off;
	logic [CNT_W-1:0]    n;
	logic [15:0]         left;
	logic [CHUNK_W-1:0]  room;
	sfc_res_t            rc [MAX_RES];

	always_comb begin
		ph   = phase_q;
		ac   = cmd_q;
		cur  = cur_q;
		rem  = rem_q;
		chk  = chk_q;
		hix  = hix_q;
		ida  = ida_q;
		off  = off_q;
		n    = '0;
		left = '0;
		room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(off_q);
		for (int i = 0; i < MAX_RES; i++) rc[i] = '0;

		if (fire) begin
			case (item.action)
				ACT_START: begin
					if (ph == PH_IDLE) begin
						ac  = item.command;
						cur = item.address;
						rem = item.length;
						chk = '0;
						hix = '0;
						ida = '0;
						off = item_off;
						if (ac > CMD_WAKE) begin
							rc[n[IDX_W-1:0]] = done_res(ac, ida); n = n + 1'b1;
							ph = PH_IDLE;
						end else if (needs_wren(ac)) begin
							rc[n[IDX_W-1:0]] = send_res(OP_WREN); n = n + 1'b1;
							ph = PH_WREN;
						end else begin
							rc[n[IDX_W-1:0]] = send_res(header_byte(3'd0, ac, cur)); n = n + 1'b1;
							ph = PH_HDR;
						end
					end
				end
				ACT_HOST: begin
					if (ph == PH_DREQ) begin
						rc[n[IDX_W-1:0]] = send_res(item.data_byte); n = n + 1'b1;
						if (ac == CMD_WRITE) begin
							chk = chk - 1'b1;
							rem = rem - 1'b1;
							// page offset follows the cursor, reset at the page end or on 24-bit wrap
							if (cur == 24'hFFFFFF || off == OFF_W'(PAGE_BYTES - 1)) off = '0;
							else off = off + 1'b1;
							cur = cur + 1'b1;
						end else if (ac == CMD_SECWR) begin
							rem = rem - 1'b1;
						end else begin
							chk = chk - 1'b1;
						end
						ph = PH_DWAIT;
					end
				end
				ACT_SPI: begin
					case (ph)
						PH_WREN: begin
							rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
							if (ac == CMD_SERASE || ac == CMD_SECER) begin
								rc[n[IDX_W-1:0]] = send_res(OP_RDSR1); n = n + 1'b1;
								ph = PH_PRE_CMD;
							end else begin
								if (ac == CMD_WRITE) begin
									// chunk stops at the next page boundary
									if (17'(rem) < 17'(room)) chk = CHUNK_W'(rem);
									else chk = room;
								end
								hix = '0;
								rc[n[IDX_W-1:0]] = send_res(header_byte(3'd0, ac, cur)); n = n + 1'b1;
								ph = PH_HDR;
							end
						end
						PH_HDR: begin
							hix = hix + 1'b1;
							if (hix < hdr_len(ac)) begin
								rc[n[IDX_W-1:0]] = send_res(header_byte(hix, ac, cur)); n = n + 1'b1;
							end else begin
								case (ac) inside
									CMD_READ, CMD_SECRD: begin
										if (rem != '0) begin
											rc[n[IDX_W-1:0]] = send_res(OP_DUMMY); n = n + 1'b1;
											ph = PH_READ;
										end else begin
											rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
											rc[n[IDX_W-1:0]] = done_res(ac, ida); n = n + 1'b1;
											ph = PH_IDLE;
										end
									end
									CMD_WRITE, CMD_SECWR: begin
										if ((ac == CMD_WRITE) ? (chk != '0) : (rem != '0)) begin
											rc[n[IDX_W-1:0]] = req_res(); n = n + 1'b1;
											ph = PH_DREQ;
										end else begin
											rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
											rc[n[IDX_W-1:0]] = send_res(OP_RDSR1); n = n + 1'b1;
											ph = PH_POST_CMD;
										end
									end
									CMD_WRST: begin
										chk = CHUNK_W'(2);
										rc[n[IDX_W-1:0]] = req_res(); n = n + 1'b1;
										ph = PH_DREQ;
									end
									CMD_SERASE, CMD_CERASE, CMD_SECER: begin
										rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
										rc[n[IDX_W-1:0]] = send_res(OP_RDSR1); n = n + 1'b1;
										ph = PH_POST_CMD;
									end
									CMD_ID, CMD_ST1, CMD_ST2: begin
										ida = '0;
										chk = (ac == CMD_ID) ? CHUNK_W'(3) : CHUNK_W'(1);
										rc[n[IDX_W-1:0]] = send_res(OP_DUMMY); n = n + 1'b1;
										ph = PH_READ;
									end
									default: begin
										rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
										rc[n[IDX_W-1:0]] = done_res(ac, ida); n = n + 1'b1;
										ph = PH_IDLE;
									end
								endcase
							end
						end
						PH_PRE_CMD: begin
							rc[n[IDX_W-1:0]] = send_res(OP_DUMMY); n = n + 1'b1;
							ph = PH_PRE_WAIT;
						end
						PH_POST_CMD: begin
							rc[n[IDX_W-1:0]] = send_res(OP_DUMMY); n = n + 1'b1;
							ph = PH_POST_WAIT;
						end
						PH_PRE_WAIT: begin
							if (item.data_byte[0]) begin
								rc[n[IDX_W-1:0]] = send_res(OP_DUMMY); n = n + 1'b1;
							end else begin
								rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
								hix = '0;
								rc[n[IDX_W-1:0]] = send_res(header_byte(3'd0, ac, cur)); n = n + 1'b1;
								ph = PH_HDR;
							end
						end
						PH_POST_WAIT: begin
							if (item.data_byte[0]) begin
								rc[n[IDX_W-1:0]] = send_res(OP_DUMMY); n = n + 1'b1;
							end else begin
								rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
								if (ac == CMD_WRITE && rem != '0) begin
									rc[n[IDX_W-1:0]] = send_res(OP_WREN); n = n + 1'b1;
									ph = PH_WREN;
								end else begin
									rc[n[IDX_W-1:0]] = done_res(ac, ida); n = n + 1'b1;
									ph = PH_IDLE;
								end
							end
						end
						PH_DWAIT: begin
							left = (ac == CMD_SECWR) ? rem : 16'(chk);
							if (left != '0) begin
								rc[n[IDX_W-1:0]] = req_res(); n = n + 1'b1;
								ph = PH_DREQ;
							end else begin
								rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
								if (ac == CMD_WRST) begin
									rc[n[IDX_W-1:0]] = done_res(ac, ida); n = n + 1'b1;
									ph = PH_IDLE;
								end else begin
									rc[n[IDX_W-1:0]] = send_res(OP_RDSR1); n = n + 1'b1;
									ph = PH_POST_CMD;
								end
							end
						end
						PH_READ: begin
							if (ac == CMD_READ || ac == CMD_SECRD) begin
								rc[n[IDX_W-1:0]] = read_res(item.data_byte); n = n + 1'b1;
								rem  = rem - 1'b1;
								left = rem;
							end else begin
								ida  = {ida[15:0], item.data_byte};
								chk  = chk - 1'b1;
								left = 16'(chk);
							end
							if (left != '0) begin
								rc[n[IDX_W-1:0]] = send_res(OP_DUMMY); n = n + 1'b1;
							end else begin
								rc[n[IDX_W-1:0]] = rel_res(); n = n + 1'b1;
								rc[n[IDX_W-1:0]] = done_res(ac, ida); n = n + 1'b1;
								ph = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign res     = rc;
	assign res_cnt = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= '0;
			cur_q   <= '0;
			rem_q   <= '0;
			chk_q   <= '0;
			hix_q   <= '0;
			ida_q   <= '0;
			off_q   <= '0;
		end else begin
			phase_q <= ph;
			cmd_q   <= ac;
			cur_q   <= cur;
			rem_q   <= rem;
			chk_q   <= chk;
			hix_q   <= hix;
			ida_q   <= ida;
			off_q   <= off;
		end
	end

endmodule

FILE: sv/sfc_out_buf.sv
// ---------------------------------------------------------------------------
// sfc_out_buf: result register bank drained one result per cycle while evt.ready is high
// Holds the results of one request and presents them in order.
// ---------------------------------------------------------------------------
module sfc_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  sfc_pkg::sfc_res_t           res [sfc_pkg::MAX_RES],
	input  logic [sfc_pkg::CNT_W-1:0]   res_cnt,
	output logic                        free,
	sfc_out_if.source                   evt
);
	import sfc_pkg::*;

	sfc_res_t          res_q [MAX_RES];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_nxt;
	logic              vld;
	logic              pop;
	sfc_res_t          cur;

	assign idx_nxt = idx_q + 1'b1;
	assign vld     = idx_q < cnt_q;
	assign pop     = vld && evt.ready;
	assign free    = !vld || (pop && idx_nxt == cnt_q);
	assign cur     = res_q[idx_q[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= res_cnt;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res;
	end

	assign evt.valid        = vld;
	assign evt.out_kind     = cur.kind;
	assign evt.spi_byte     = cur.spi;
	assign evt.host_byte    = cur.host;
	assign evt.result_value = cur.value;
	assign evt.last         = idx_nxt == cnt_q;

endmodule

FILE: sv/spi_nor_flash_command_sequencer.sv
// ---------------------------------------------------------------------------
// spi_nor_flash_command_sequencer: SPI NOR flash command sequencer
// Turns host commands into SPI byte, chip-select and host data results.
// ---------------------------------------------------------------------------
// Usage:
//   cmd (sink): one request per handshake. action selects start command,
//   host write byte or SPI byte received. Every send result must later be
//   answered by one SPI-byte request, every write-byte request by one
//   host-byte request; requests that do not fit the current step are dropped.
//   evt (source): results in order, last marks the final result of a request.
//   Path: a request is registered, then passes two more stages that
//   reduce the address modulo PAGE_BYTES; once the result bank is free
//   its results are registered there and presented in order.
//   Throughput: one request per cycle while each yields at most one result
//   and evt.ready stays high; a request with n results (n up to 3) holds
//   the single result register bank until all n are drained, one entry
//   per cycle, and the next request waits for it.
//   Reset: sequencer idle, all counters cleared and the result bank emptied.
//   Stall: when evt.ready is low the result bank holds, the input stages fill,
//   and cmd.ready drops once all three are occupied.
// ---------------------------------------------------------------------------
module spi_nor_flash_command_sequencer #(
	parameter int PAGE_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	sfc_in_if.sink     cmd,
	sfc_out_if.source  evt
);
	import sfc_pkg::*;

	localparam int OFF_W = $clog2(PAGE_BYTES);

	logic              vld;
	logic              fire;
	logic              free;
	sfc_item_t         item;
	logic [OFF_W-1:0]  item_off;
	sfc_res_t          res [MAX_RES];
	logic [CNT_W-1:0]  res_cnt;

	assign fire = vld && free;

	sfc_in_pipe #(.PAGE_BYTES(PAGE_BYTES)) u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.take   (fire),
		.vld    (vld),
		.item   (item),
		.off    (item_off)
	);

	sfc_core #(.PAGE_BYTES(PAGE_BYTES)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item),
		.item_off (item_off),
		.res      (res),
		.res_cnt  (res_cnt)
	);

	sfc_out_buf u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.res     (res),
		.res_cnt (res_cnt),
		.free    (free),
		.evt     (evt)
	);

endmodule

FILE: sv/sfc_checker.sv
// ---------------------------------------------------------------------------
// sfc_checker: port-level checks on the sequencer result channel
// Result ordering rules and handshake hold, bound to the top level.
// ---------------------------------------------------------------------------
module sfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  out_kind,
	input logic [7:0]  spi_byte,
	input logic        last
);
	import sfc_pkg::*;

	// stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_kind) && $stable(spi_byte) && $stable(last))
		else $error("result changed while stalled");

	// done ends a request's result group
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_kind == KIND_DONE |-> last)
		else $error("done not marked last");

	// a write-byte request waits for the host, nothing follows it
	a_req_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_kind == KIND_REQ |-> last)
		else $error("write-byte request not last");

	// read byte is always followed by a dummy send or a release
	a_read_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_kind == KIND_READ |-> !last)
		else $error("read byte marked last");

	a_spi_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_kind != KIND_SEND |-> spi_byte == 8'h00)
		else $error("spi byte set on a non-send result");

endmodule

bind spi_nor_flash_command_sequencer sfc_checker u_sfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.valid    (evt.valid),
	.ready    (evt.ready),
	.out_kind (evt.out_kind),
	.spi_byte (evt.spi_byte),
	.last     (evt.last)
);
